>>> design/kmp_pkg.sv
// ============================================================================
// kmp_pkg
// Types and constants shared by the KMP pattern matcher modules.
// ============================================================================
package kmp_pkg;

  localparam int unsigned SYM_W = 8;   // width of a pattern or text byte
  localparam int unsigned POS_W = 32;  // width of the text position

  // Sequencer states of the search controller.
  typedef enum logic [1:0] {
    ST_IDLE,   // waiting for an item
    ST_WALK,   // comparing a stored byte, following failure links
    ST_MATCH,  // occurrence complete, reading the failure value of the last entry
    ST_EMIT    // result known at acceptance, waiting to hand it over
  } kmp_state_t;

  // One result item as handed from the controller to the output stage.
  typedef struct packed {
    logic             status;
    logic [POS_W-1:0] match_start;
    logic             match_found;
  } kmp_result_t;

endpackage

>>> design/kmp_pattern_matcher_top.sv
// ============================================================================
// kmp_pattern_matcher_top
// Streaming Knuth-Morris-Pratt byte search with an incrementally built
// failure table and a registered result stage.
// ============================================================================
// Pattern items append one byte to the stored pattern and build its failure
// entry; text items are searched against the stored pattern, and every text
// byte that completes an occurrence reports the position of the occurrence's
// first byte, overlapping occurrences included. Every item yields exactly one
// result item. The controller takes no new item until the result of the
// last one is handed to the output register. Each failure link followed
// adds a step to the read loop through the pattern and failure memories,
// which have registered reads, and a text byte that completes an occurrence
// adds a further read of its failure value. Over a stream, failure-link
// steps average at most one per byte. A pattern byte that arrives while the
// store holds MAX_PATTERN bytes is dropped and its result carries the status
// flag. The text position stops at its largest value. The memories need no
// clearing after reset: only written entries are read.
module kmp_pattern_matcher_top
  import kmp_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic [1:0]  in_tuser,   // [0] operation, [1] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] match_start
  output logic [1:0]  out_tuser   // [0] match_found, [1] status
);

  logic        res_valid;
  logic        res_ready;
  kmp_result_t res;

  kmp_ctrl #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_tvalid),
    .item_ready  (in_tready),
    .item_op     (in_tuser[0]),
    .item_sym    (in_tdata),
    .item_restart(in_tuser[1]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register: the controller may hand over a new result whenever the
  // register is empty or its item is being taken in the same cycle.
  logic        out_valid_r;
  kmp_result_t out_res_r;

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.match_start;
  assign out_tuser  = {out_res_r.status, out_res_r.match_found};

endmodule

>>> design/kmp_ctrl.sv
// ============================================================================
// kmp_ctrl
// Sequencer of the KMP matcher: owns the pattern and failure memories,
// appends pattern bytes and walks failure links for pattern and text bytes.
// ============================================================================
module kmp_ctrl
  import kmp_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic              item_op,
  input  logic [SYM_W-1:0]  item_sym,
  input  logic              item_restart,
  output logic              res_valid,
  input  logic              res_ready,
  output kmp_result_t       res
);

  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PATTERN + 1);

  // Memories: pattern bytes and failure values, registered reads.
  logic [SYM_W-1:0] pat_mem  [MAX_PATTERN];
  logic [IDX_W-1:0] fail_mem [MAX_PATTERN];

  logic             pat_we, fail_we;
  logic [IDX_W-1:0] pat_waddr, fail_waddr, pat_raddr, fail_raddr;
  logic [SYM_W-1:0] pat_wdata, pat_rdata_r;
  logic [IDX_W-1:0] fail_wdata, fail_rdata_r;

  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_mem[pat_waddr] <= pat_wdata;
    end
    pat_rdata_r <= pat_mem[pat_raddr];
  end

  always_ff @(posedge clk) begin
    if (fail_we) begin
      fail_mem[fail_waddr] <= fail_wdata;
    end
    fail_rdata_r <= fail_mem[fail_raddr];
  end

  // Control and payload registers.
  kmp_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] bpl_r, bpl_nxt;
  logic [IDX_W-1:0] mlen_r, mlen_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             op_r, op_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic             status_r, status_nxt;
  logic [POS_W-1:0] item_pos_r, item_pos_nxt;
  logic [POS_W-1:0] start_r, start_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      bpl_r   <= '0;
      mlen_r  <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      bpl_r   <= bpl_nxt;
      mlen_r  <= mlen_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    sym_r      <= sym_nxt;
    j_r        <= j_nxt;
    status_r   <= status_nxt;
    item_pos_r <= item_pos_nxt;
    start_r    <= start_nxt;
  end

  // Values seen by an item at acceptance, after any restart has taken effect.
  logic             restart_pat;
  logic [CNT_W-1:0] eff_count;
  logic [IDX_W-1:0] eff_bpl, eff_mlen, j_start;
  logic [POS_W-1:0] eff_pos;
  logic             full, trivial, hit, walk_done, is_match;
  logic [CNT_W-1:0] jn;

  always_comb begin
    restart_pat = item_restart && !item_op;
    eff_count   = restart_pat ? '0 : count_r;
    eff_bpl     = restart_pat ? '0 : bpl_r;
    eff_mlen    = item_restart ? '0 : mlen_r;
    eff_pos     = (item_restart && item_op) ? '0 : pos_r;
    j_start     = (CNT_W'(eff_mlen) >= count_r) ? '0 : eff_mlen;
    full        = (eff_count == CNT_W'(MAX_PATTERN));
    trivial     = item_op ? (count_r == '0) : (full || (eff_count == '0));
    hit         = (pat_rdata_r == sym_r);
    walk_done   = hit || (j_r == '0);
    jn          = hit ? (CNT_W'(j_r) + CNT_W'(1)) : '0;
    is_match    = op_r && (jn == count_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          state_nxt = trivial ? ST_EMIT : ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          if (is_match) begin
            state_nxt = ST_MATCH;
          end else if (res_ready) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MATCH, ST_EMIT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs, memory accesses and register updates.
  always_comb begin
    item_ready   = (state_r == ST_IDLE);
    res_valid    = 1'b0;
    res          = '0;
    pat_we       = 1'b0;
    pat_waddr    = eff_count[IDX_W-1:0];
    pat_wdata    = item_sym;
    fail_we      = 1'b0;
    fail_waddr   = count_r[IDX_W-1:0];
    fail_wdata   = jn[IDX_W-1:0];
    pat_raddr    = j_r;
    fail_raddr   = j_r - IDX_W'(1);
    count_nxt    = count_r;
    bpl_nxt      = bpl_r;
    mlen_nxt     = mlen_r;
    pos_nxt      = pos_r;
    op_nxt       = op_r;
    sym_nxt      = sym_r;
    j_nxt        = j_r;
    status_nxt   = status_r;
    item_pos_nxt = item_pos_r;
    start_nxt    = start_r;

    unique case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          op_nxt    = item_op;
          sym_nxt   = item_sym;
          mlen_nxt  = eff_mlen;
          count_nxt = eff_count;
          bpl_nxt   = eff_bpl;
          if (!item_op) begin
            status_nxt = full;
            if (!full) begin
              pat_we = 1'b1;
              if (eff_count == '0) begin
                // First byte: its failure value is zero by definition.
                fail_we    = 1'b1;
                fail_waddr = '0;
                fail_wdata = '0;
                count_nxt  = CNT_W'(1);
                bpl_nxt    = '0;
              end else begin
                j_nxt      = eff_bpl;
                pat_raddr  = eff_bpl;
                fail_raddr = eff_bpl - IDX_W'(1);
              end
            end
          end else begin
            status_nxt   = 1'b0;
            item_pos_nxt = eff_pos;
            pos_nxt      = (&eff_pos) ? eff_pos : (eff_pos + POS_W'(1));
            j_nxt        = j_start;
            pat_raddr    = j_start;
            fail_raddr   = j_start - IDX_W'(1);
          end
        end
      end
      ST_WALK: begin
        if (!walk_done) begin
          j_nxt      = fail_rdata_r;
          pat_raddr  = fail_rdata_r;
          fail_raddr = fail_rdata_r - IDX_W'(1);
        end else if (op_r) begin
          if (is_match) begin
            start_nxt  = item_pos_r - POS_W'(count_r) + POS_W'(1);
            fail_raddr = IDX_W'(count_r - CNT_W'(1));
          end else begin
            res_valid = 1'b1;
            if (res_ready) begin
              mlen_nxt = jn[IDX_W-1:0];
            end
          end
        end else begin
          res_valid = 1'b1;
          if (res_ready) begin
            fail_we   = 1'b1;
            bpl_nxt   = jn[IDX_W-1:0];
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      ST_MATCH: begin
        fail_raddr      = IDX_W'(count_r - CNT_W'(1));
        res_valid       = 1'b1;
        res.match_found = 1'b1;
        res.match_start = start_r;
        if (res_ready) begin
          mlen_nxt = fail_rdata_r;
        end
      end
      ST_EMIT: begin
        res_valid  = 1'b1;
        res.status = status_r;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

endmodule

>>> design/kmp_checker.sv
// ============================================================================
// kmp_checker
// Port-level checks on the KMP pattern matcher, bound to its top level.
// ============================================================================
module kmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A waiting result item holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // The controller works on one item at a time: it never accepts items back to back.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted in back-to-back cycles");

  // A dropped pattern byte never reports an occurrence.
  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && (out_tdata == 32'd0))
    else $error("status and match flags both set");

  // Without an occurrence the start position reads zero.
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata == 32'd0))
    else $error("match start set without a match");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind kmp_pattern_matcher_top kmp_checker u_kmp_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the streaming KMP byte search block. Pattern and
// text items are driven on the input stream, every accepted item is run
// through a local model of the matcher, and each result item is compared
// field by field with the oldest outstanding prediction.
// ============================================================================
module testbench;
  import kmp_pkg::*;

  localparam int unsigned MAX_PATTERN = 32;
  // Settling time: enough for the slowest item, which follows at most a
  // pattern's length of failure links, with some margin on top.
  localparam int unsigned DRAIN_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned MAX_REPORTS = 10;

  // Item kinds as carried in bit 0 of in_tuser.
  typedef enum bit {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] symbol
  logic [1:0]  in_tuser   = 2'b00;  // [0] operation, [1] restart
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [31:0] match_start
  logic [1:0]  out_tuser;           // [0] match_found, [1] status

  // Idling rates, in percent, changed from phase to phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Results predicted for accepted items, oldest first.
  kmp_result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;

  // Local copy of the matcher state.
  logic [7:0]  pat_bytes [MAX_PATTERN];
  logic [5:0]  fail_len  [MAX_PATTERN];
  int unsigned pat_len   = 0;
  int unsigned build_len = 0;
  int unsigned match_len = 0;
  logic [31:0] text_pos  = '0;

  // Small alphabet for the random traffic, so that matches are frequent.
  logic [7:0]  letters [3];
  int unsigned letter_count = 1;

  kmp_pattern_matcher_top #(
    .MAX_PATTERN(MAX_PATTERN)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Works out the result of one accepted item and advances the local state.
  // Pattern items extend the pattern and its failure table; text items walk
  // the failure links until the byte fits or the matched length is zero.
  function automatic kmp_result_t predict_match(op_t op, logic [7:0] sym, bit restart);
    kmp_result_t res;
    int unsigned k;
    res = '0;
    if (op == OP_PATTERN) begin
      if (restart) begin
        pat_len   = 0;
        build_len = 0;
        match_len = 0;
      end
      if (pat_len >= MAX_PATTERN) begin
        res.status = 1'b1;
      end else begin
        pat_bytes[pat_len] = sym;
        k = 0;
        if (pat_len != 0) begin
          k = build_len;
          while (k > 0 && pat_bytes[k] != sym) k = fail_len[k-1];
          if (pat_bytes[k] == sym) k++;
        end
        fail_len[pat_len] = 6'(k);
        build_len = k;
        pat_len++;
      end
    end else begin
      if (restart) begin
        text_pos  = '0;
        match_len = 0;
      end
      if (pat_len > 0) begin
        k = (match_len >= pat_len) ? 0 : match_len;
        while (k > 0 && pat_bytes[k] != sym) k = fail_len[k-1];
        if (pat_bytes[k] == sym) k++;
        if (k == pat_len) begin
          res.match_found = 1'b1;
          res.match_start = text_pos - 32'(pat_len - 1);
          k = fail_len[k-1];
        end
        match_len = k;
      end
      // The position stops at its largest value rather than wrapping.
      if (text_pos != '1) text_pos = text_pos + 32'd1;
    end
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] wanted, logic [31:0] seen);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("tb: %s mismatch at cycle %0d: expected 0x%08h, got 0x%08h",
               what, cycles, wanted, seen);
  endtask

  // Every result item is checked against the oldest prediction.
  always @(posedge clk) begin : check_results
    kmp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: result with nothing outstanding at cycle %0d: tdata 0x%08h tuser %b",
                   cycles, out_tdata, out_tuser);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[0] !== want.match_found)
          note_mismatch("match_found", 32'(want.match_found), 32'(out_tuser[0]));
        if (out_tdata !== want.match_start)
          note_mismatch("match_start", want.match_start, out_tdata);
        if (out_tuser[1] !== want.status)
          note_mismatch("status", 32'(want.status), 32'(out_tuser[1]));
      end
    end
  end

  // Sends one item. The valid line is left high after acceptance so that a
  // following item can go out on the very next cycle; anything that pauses
  // the sender lowers it first. A random gap is inserted before the item.
  task automatic send_item(op_t op, logic [7:0] sym, bit restart);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tuser  <= {restart, op};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_match(op, sym, restart));
  endtask

  // Holds the sender off until every predicted result has come back, then
  // lets the block settle for as long as its slowest item could take.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Text bytes with no pattern stored never match, but the position moves.
  task automatic test_empty_pattern();
    send_item(OP_TEXT, 8'h00, 1'b0);
    send_item(OP_TEXT, 8'hFF, 1'b1);
  endtask

  // "aba" searched in "ababa" gives two overlapping hits; the pattern is then
  // grown to "abab" in the middle of the search and the matched length kept.
  task automatic test_overlapping_matches();
    send_item(OP_PATTERN, 8'h61, 1'b1);
    send_item(OP_PATTERN, 8'h62, 1'b0);
    send_item(OP_PATTERN, 8'h61, 1'b0);
    send_item(OP_TEXT,    8'h61, 1'b1);
    send_item(OP_TEXT,    8'h62, 1'b0);
    send_item(OP_TEXT,    8'h61, 1'b0);
    send_item(OP_TEXT,    8'h62, 1'b0);
    send_item(OP_TEXT,    8'h61, 1'b0);
    send_item(OP_PATTERN, 8'h62, 1'b0);
    send_item(OP_TEXT,    8'h62, 1'b0);
    send_item(OP_TEXT,    8'h61, 1'b0);
    send_item(OP_TEXT,    8'h62, 1'b0);
  endtask

  // All-zero and all-one bytes as pattern and text, with a text restart.
  task automatic test_symbol_extremes();
    send_item(OP_PATTERN, 8'hFF, 1'b1);
    send_item(OP_PATTERN, 8'h00, 1'b0);
    send_item(OP_PATTERN, 8'hFF, 1'b0);
    send_item(OP_TEXT,    8'hFF, 1'b0);
    send_item(OP_TEXT,    8'h00, 1'b0);
    send_item(OP_TEXT,    8'hFF, 1'b0);
    send_item(OP_TEXT,    8'h00, 1'b0);
    send_item(OP_TEXT,    8'hFF, 1'b0);
    send_item(OP_TEXT,    8'hFF, 1'b1);
    send_item(OP_TEXT,    8'h00, 1'b0);
    send_item(OP_TEXT,    8'hFF, 1'b0);
  endtask

  // Fills the store with a run of 'a' closed by 'b', which gives the longest
  // failure chains, drops a few bytes past capacity, and searches a long run
  // of 'a' so that the final mismatch walks every link back to zero.
  task automatic test_store_full();
    int unsigned i;
    for (i = 0; i < MAX_PATTERN - 1; i++) send_item(OP_PATTERN, 8'h61, i == 0);
    send_item(OP_PATTERN, 8'h62, 1'b0);
    send_item(OP_PATTERN, 8'h00, 1'b0);
    send_item(OP_PATTERN, 8'hFF, 1'b0);
    send_item(OP_PATTERN, 8'h62, 1'b0);
    for (i = 0; i < 36; i++) send_item(OP_TEXT, 8'h61, i == 0);
    send_item(OP_TEXT, 8'h62, 1'b0);
    for (i = 0; i < MAX_PATTERN; i++) send_item(OP_TEXT, 8'h61, 1'b0);
    send_item(OP_TEXT, 8'h63, 1'b0);
    // A restart frees the store again.
    send_item(OP_PATTERN, 8'h5A, 1'b1);
    send_item(OP_TEXT,    8'h5A, 1'b0);
  endtask

  task automatic pick_alphabet();
    letter_count = $urandom_range(1, 3);
    foreach (letters[i]) letters[i] = 8'($urandom);
  endtask

  // Mostly letters of the current alphabet, now and then any byte at all.
  function automatic logic [7:0] alphabet_symbol();
    if ($urandom_range(0, 19) == 0) return 8'($urandom);
    return letters[$urandom_range(0, letter_count - 1)];
  endfunction

  // Random traffic built from well-formed runs: a fresh pattern, a few bytes
  // appended to the current pattern, or a run of text over the same alphabet.
  // A small share of the runs is plain noise with every field random.
  task automatic test_random_stream(int unsigned send_pct, int unsigned stall_pct,
                                    int unsigned n_items);
    int unsigned sent, len, pick, i;
    set_idling(send_pct, stall_pct);
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        len = $urandom_range(1, 6);
        repeat (len) send_item(op_t'($urandom_range(0, 1)), 8'($urandom), 1'($urandom));
      end else if (pick < 22) begin
        pick_alphabet();
        // Mostly short patterns; a few long ones, some long enough to overflow the store.
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, MAX_PATTERN + 3)
                                           : $urandom_range(1, 5);
        for (i = 0; i < len; i++) send_item(OP_PATTERN, alphabet_symbol(), i == 0);
      end else if (pick < 28) begin
        len = $urandom_range(1, 2);
        repeat (len) send_item(OP_PATTERN, alphabet_symbol(), 1'b0);
      end else begin
        len = $urandom_range(4, 24);
        for (i = 0; i < len; i++)
          send_item(OP_TEXT, alphabet_symbol(), i == 0 && $urandom_range(0, 9) == 0);
      end
      sent += len;
    end
  endtask

  initial begin
    letters[0] = 8'h61;
    letters[1] = 8'h62;
    letters[2] = 8'h63;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0, 0);
    test_empty_pattern();
    test_overlapping_matches();
    wait_drained();
    set_idling(35, 35);
    test_symbol_extremes();
    wait_drained();
    set_idling(0, 71);
    test_store_full();
    wait_drained();

    // Four idling phases: none, a slow sender, a slow receiver, both.
    test_random_stream(0, 0, 400);
    wait_drained();
    test_random_stream(71, 0, 400);
    wait_drained();
    test_random_stream(0, 71, 400);
    wait_drained();
    test_random_stream(35, 35, 400);

    set_idling(0, 0);
    wait_drained();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
design/kmp_pkg.sv
design/kmp_ctrl.sv
design/kmp_pattern_matcher_top.sv
design/kmp_checker.sv
tb/testbench.sv
